>>> sv/min_current_limit_voter_core_macros.svh
// Assertion macros for the min current limit voter core.
// Included by the RTL files that carry concurrent checks; no dependencies.
`ifndef MIN_CURRENT_LIMIT_VOTER_CORE_MACROS_SVH
`define MIN_CURRENT_LIMIT_VOTER_CORE_MACROS_SVH

// Check a property on every rising edge outside reset.
`define MCLV_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mclv check failed");

// Check that a condition implies another one in the same cycle.
`define MCLV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mclv implication failed");

`endif

>>> sv/mclv_pkg.sv
// Shared types and constants of the min current limit voter core.
// No dependencies; imported by the interfaces and all modules.
`default_nettype none

package mclv_pkg;

  localparam int LIMIT_W = 16;
  localparam int MASK_W  = 16;
  localparam logic [LIMIT_W-1:0] RELEASED_LIMIT = 16'hFFFF;

  // Current types carried in voter_type and out_type.
  localparam logic [1:0] TYPE_USB  = 2'd0;
  localparam logic [1:0] TYPE_BATT = 2'd1;
  localparam logic [1:0] TYPE_DC   = 2'd2;

  typedef enum logic [1:0] {
    KIND_REGISTER   = 2'd0,
    KIND_UNREGISTER = 2'd1,
    KIND_SET        = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         voter_slot;
    logic [1:0]         voter_type;
    logic [LIMIT_W-1:0] new_limit;
  } req_t;

  typedef struct packed {
    logic [1:0]         out_type;
    logic [LIMIT_W-1:0] effective_limit;
    logic [MASK_W-1:0]  effected_mask;
  } rsp_t;

  // One entry of the slot memory.
  typedef struct packed {
    logic [1:0]         typ;
    logic [LIMIT_W-1:0] limit;
  } slot_ent_t;

  // Per-cycle control of the minimum accumulator.
  typedef struct packed {
    logic               clear;
    logic               hit;
    logic [LIMIT_W-1:0] limit;
    logic [MASK_W-1:0]  mbit;
  } scan_ctl_t;

endpackage

`default_nettype wire

>>> sv/mclv_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on mclv_pkg for the payload structs.
`default_nettype none

interface mclv_req_if import mclv_pkg::*;;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mclv_rsp_if import mclv_pkg::*;;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/mclv_slot_mem.sv
// Slot memory: type and limit per voter slot, one write and one read port.
// Read data is registered. Depends on mclv_pkg.
`default_nettype none

module mclv_slot_mem import mclv_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  slot_ent_t     wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output slot_ent_t     rdata_o
);

  slot_ent_t mem_q [DEPTH];
  slot_ent_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> sv/mclv_min_scan.sv
// Running minimum and tie mask over the slots read during a scan.
// Depends on mclv_pkg for scan_ctl_t.
`default_nettype none

module mclv_min_scan import mclv_pkg::*; (
  input  logic               clk_i,
  input  scan_ctl_t          ctl_i,
  output logic [LIMIT_W-1:0] best_o,
  output logic [MASK_W-1:0]  mask_o
);

  logic [LIMIT_W-1:0] best_q, best_d;
  logic [MASK_W-1:0]  mask_q, mask_d;

  always_comb begin
    best_d = best_q;
    mask_d = mask_q;
    if (ctl_i.clear) begin
      best_d = RELEASED_LIMIT;
      mask_d = '0;
    end else if (ctl_i.hit) begin
      // strictly lower: restart the mask; equal: add the slot
      if (ctl_i.limit < best_q) begin
        best_d = ctl_i.limit;
        mask_d = ctl_i.mbit;
      end else if (ctl_i.limit == best_q) begin
        mask_d = mask_q | ctl_i.mbit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    mask_q <= mask_d;
  end

  assign best_o = best_q;
  assign mask_o = mask_q;

endmodule

`default_nettype wire

>>> sv/min_current_limit_voter_core.sv
// Min current limit voter core: slot table in memory, sequenced scan for the
// minimum limit of one type. Depends on mclv_pkg, mclv_if, mclv_slot_mem,
// mclv_min_scan and the assertion macro header.
//
//   channel  dir  payload                                  transfer
//   req_i    in   kind, voter_slot, voter_type, new_limit  valid & ready
//   rsp_o    out  out_type, effective_limit, effected_mask valid & ready
//
// Register and unregister complete in idle; an unchanged set ends at the check.
// A changed set reads its slot, checks and writes back, then scans one entry per
// cycle. New requests are accepted only in idle, not while a set is in progress.
// Reset is asynchronous, active low; it clears the valid and written marks.
// A result waits in the output register while the next request is taken;
// only a second result stalls until the first transfer completes.
`default_nettype none

`include "min_current_limit_voter_core_macros.svh"

module min_current_limit_voter_core import mclv_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mclv_req_if.sink   req_i,
  mclv_rsp_if.source rsp_o
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  state_e state_q, state_d;

  req_t                  item_q;
  logic [NUM_SLOTS-1:0]  valid_q, written_q;
  logic [1:0]            type_q;
  logic [CW-1:0]         issue_q, issue_d;
  logic                  rd_vld_q;
  logic [IW-1:0]         rd_idx_q;
  logic                  out_vld_q;
  rsp_t                  out_q;

  logic          acc, in_range, reg_ok, out_free;
  logic [IW-1:0] in_slot, item_slot;
  logic          changed;
  logic [LIMIT_W-1:0] cur_limit;

  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  slot_ent_t     mem_wdata, mem_rdata;

  scan_ctl_t          scan_ctl;
  logic [LIMIT_W-1:0] best;
  logic [MASK_W-1:0]  mask;

  assign req_i.ready = (state_q == ST_IDLE);
  assign acc         = req_i.valid & req_i.ready;
  assign in_range    = int'(req_i.data.voter_slot) < NUM_SLOTS;
  assign in_slot     = IW'(req_i.data.voter_slot);
  assign item_slot   = IW'(item_q.voter_slot);
  assign reg_ok      = (req_i.data.voter_type == TYPE_USB) ||
                       (req_i.data.voter_type == TYPE_BATT) ||
                       (req_i.data.voter_type == TYPE_DC);
  assign out_free    = !out_vld_q || rsp_o.ready;

  // Unwritten entries read as released.
  assign cur_limit = written_q[item_slot] ? mem_rdata.limit : RELEASED_LIMIT;
  assign changed   = (cur_limit != item_q.new_limit);

  mclv_slot_mem #(
    .DEPTH (NUM_SLOTS),
    .AW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  mclv_min_scan u_scan (
    .clk_i  (clk_i),
    .ctl_i  (scan_ctl),
    .best_o (best),
    .mask_o (mask)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && in_range && (req_i.data.kind == KIND_SET)) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = changed ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        if ((issue_q == CW'(NUM_SLOTS)) && !rd_vld_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory and scan control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = in_slot;
    mem_wdata = '{typ: req_i.data.voter_type, limit: RELEASED_LIMIT};
    mem_re    = 1'b0;
    mem_raddr = in_slot;
    issue_d   = issue_q;
    scan_ctl  = '{clear: 1'b0, hit: 1'b0, limit: mem_rdata.limit, mbit: '0};
    case (state_q)
      ST_IDLE: begin
        mem_re = acc && in_range && (req_i.data.kind == KIND_SET);
        mem_we = acc && in_range && (req_i.data.kind == KIND_REGISTER) && reg_ok;
      end
      ST_CHECK: begin
        // write back the new limit, keep the stored type
        mem_we         = changed;
        mem_waddr      = item_slot;
        mem_wdata      = '{typ: mem_rdata.typ, limit: item_q.new_limit};
        issue_d        = '0;
        scan_ctl.clear = 1'b1;
      end
      ST_SCAN: begin
        mem_raddr = issue_q[IW-1:0];
        if (issue_q < CW'(NUM_SLOTS)) begin
          mem_re  = 1'b1;
          issue_d = issue_q + 1'b1;
        end
        scan_ctl.hit = rd_vld_q && valid_q[rd_idx_q] && (mem_rdata.typ == type_q);
        if (int'(rd_idx_q) < MASK_W) begin
          scan_ctl.mbit = MASK_W'(1) << rd_idx_q;
        end
      end
      ST_EMIT: begin
        mem_we = 1'b0;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= '0;
      written_q <= '0;
      issue_q   <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issue_q  <= issue_d;
      rd_vld_q <= (state_q == ST_SCAN) && mem_re;
      if ((state_q == ST_IDLE) && acc && in_range) begin
        if ((req_i.data.kind == KIND_REGISTER) && reg_ok) begin
          valid_q[in_slot]   <= 1'b1;
          written_q[in_slot] <= 1'b1;
        end else if (req_i.data.kind == KIND_UNREGISTER) begin
          valid_q[in_slot] <= 1'b0;
        end
      end
      if ((state_q == ST_CHECK) && changed) begin
        written_q[item_slot] <= 1'b1;
      end
      if ((state_q == ST_EMIT) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      item_q <= req_i.data;
    end
    if (state_q == ST_CHECK) begin
      type_q <= mem_rdata.typ;
    end
    rd_idx_q <= mem_raddr;
    if ((state_q == ST_EMIT) && out_free) begin
      out_q.out_type        <= type_q;
      out_q.effective_limit <= best;
      // a released minimum reports no slots
      out_q.effected_mask   <= (best == RELEASED_LIMIT) ? '0 : mask;
    end
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

  `MCLV_ASSERT_IMPL(a_rise_after_emit, clk_i, rst_ni, $rose(out_vld_q), $past(state_q == ST_EMIT))
  `MCLV_ASSERT_IMPL(a_released_no_mask, clk_i, rst_ni, out_vld_q && (out_q.effective_limit == RELEASED_LIMIT), out_q.effected_mask == '0)
  `MCLV_ASSERT_IMPL(a_scan_complete, clk_i, rst_ni, (state_q == ST_SCAN) && (state_d == ST_EMIT), issue_q == CW'(NUM_SLOTS))
  `MCLV_ASSERT_IMPL(a_check_after_idle, clk_i, rst_ni, state_q == ST_CHECK, $past(state_q == ST_IDLE))

endmodule

`default_nettype wire
